@@ hw/rtl/cap_rvb_pkg.sv @@
package cap_rvb_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [23:0] q24_t;

  localparam int MulAW = 26;
  localparam int MulBW = 17;
  localparam int MulPW = 44;

  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic [MulBW-1:0]        mul_b_t;
  typedef logic signed [MulPW-1:0] mul_p_t;

  localparam logic [16:0] FB_SCALE  = 17'd58982;
  localparam logic [15:0] FB_OFFSET = 16'd3277;
  localparam logic [16:0] WET_MAX   = 17'd65536;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_ROOM     = 2'd1;
  localparam logic [1:0] REG_DAMPING  = 2'd2;
  localparam logic [1:0] REG_WET      = 2'd3;

  function automatic q24_t sat24(input mul_p_t x);
    if (x > 44'sd8388607) return 24'sh7fffff;
    if (x < -44'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic sample_t sat16(input mul_p_t x);
    if (x > 44'sd32767) return 16'sh7fff;
    if (x < -44'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

endpackage

@@ hw/rtl/comb_allpass_reverb_top.sv @@
// One 17-bit bit-serial multiplier is shared by all products: feedback gain,
// two per comb, one per output channel.
// One frame in flight; a finished result waits in the output register.
// Reset (synchronous) restores register defaults and runs a clearing pass over
// every word of the delay memories, with input stalled.
module comb_allpass_reverb_top #(
  parameter int COMB1_LEN = 1116,
  parameter int COMB2_LEN = 1188,
  parameter int COMB3_LEN = 1277,
  parameter int COMB4_LEN = 1356,
  parameter int AP1_LEN   = 556,
  parameter int AP2_LEN   = 441
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cap_rvb_pkg::sample_t sample_a,
  input  cap_rvb_pkg::sample_t sample_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cap_rvb_pkg::sample_t out_a,
  output cap_rvb_pkg::sample_t out_b
);
  import cap_rvb_pkg::*;

  localparam int C1W = $clog2(COMB1_LEN);
  localparam int C2W = $clog2(COMB2_LEN);
  localparam int C3W = $clog2(COMB3_LEN);
  localparam int C4W = $clog2(COMB4_LEN);
  localparam int A1W = $clog2(AP1_LEN);
  localparam int A2W = $clog2(AP2_LEN);
  localparam int M12 = COMB1_LEN > COMB2_LEN ? COMB1_LEN : COMB2_LEN;
  localparam int M34 = COMB3_LEN > COMB4_LEN ? COMB3_LEN : COMB4_LEN;
  localparam int MAP = AP1_LEN > AP2_LEN ? AP1_LEN : AP2_LEN;
  localparam int MC  = M12 > M34 ? M12 : M34;
  localparam int MAXLEN = MC > MAP ? MC : MAP;
  localparam int CLRW = $clog2(MAXLEN);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FB   = 4'd2;
  localparam logic [3:0] S_CY   = 4'd3;
  localparam logic [3:0] S_CM1  = 4'd4;
  localparam logic [3:0] S_CM2  = 4'd5;
  localparam logic [3:0] S_AP1  = 4'd6;
  localparam logic [3:0] S_AP2  = 4'd7;
  localparam logic [3:0] S_MXA  = 4'd8;
  localparam logic [3:0] S_MXB  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // configuration
  logic [1:0]  channel_count;
  logic [15:0] room_size;
  logic [15:0] damping;
  logic [16:0] wet_mix;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd2;
      room_size     <= 16'd32768;
      damping       <= 16'd32768;
      wet_mix       <= 17'd19661;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHANNELS: channel_count <= pwdata[1:0];
        REG_ROOM:     room_size     <= pwdata[15:0];
        REG_DAMPING:  damping       <= pwdata[15:0];
        REG_WET:      wet_mix       <= pwdata[16:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNELS: prdata = {30'd0, channel_count};
      REG_ROOM:     prdata = {16'd0, room_size};
      REG_DAMPING:  prdata = {16'd0, damping};
      REG_WET:      prdata = {15'd0, wet_mix};
      default:      prdata = '0;
    endcase
  end

  // control and datapath registers
  logic [3:0]        state;
  logic [CLRW-1:0]   clr_cnt;
  logic [1:0]        k;
  sample_t           sa, sb;
  logic              mono_mode;
  logic signed [20:0] mono;
  logic [15:0]       fb;
  logic [16:0]       wsat;
  q24_t              y;
  q24_t              store [4];
  q24_t              store_new;
  logic signed [26:0] sum;
  q24_t              rev;
  sample_t           res_a, res_b;

  logic [C1W-1:0] cidx1;
  logic [C2W-1:0] cidx2;
  logic [C3W-1:0] cidx3;
  logic [C4W-1:0] cidx4;
  logic [A1W-1:0] aidx1;
  logic [A2W-1:0] aidx2;

  // memories
  logic clearing;
  logic we_c1, we_c2, we_c3, we_c4, we_a1, we_a2;
  q24_t rd_c1, rd_c2, rd_c3, rd_c4, rd_a1, rd_a2;
  q24_t line_wr, ap1_wr, ap2_wr;
  logic comb_wr;

  assign clearing = (state == S_CLR);

  // multiplier
  logic   mul_start, mul_done;
  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t mul_p;

  cap_rvb_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  q24_t   comb_rd;
  q24_t   ap1_y, ap2_y;
  mul_p_t store_sum;
  mul_p_t mix_acc;
  mul_p_t mix_rnd;
  sample_t mix_o;

  always_comb begin
    case (k)
      2'd0:    comb_rd = rd_c1;
      2'd1:    comb_rd = rd_c2;
      2'd2:    comb_rd = rd_c3;
      default: comb_rd = rd_c4;
    endcase
  end

  assign store_sum = (MulPW'(y) <<< 16) + mul_p;
  assign store_new = sat24(store_sum >>> 16);
  assign line_wr   = sat24(MulPW'(mono) + (mul_p >>> 16));
  assign ap1_y  = sat24(MulPW'(rd_a1) - MulPW'(sat24(MulPW'(sum))));
  assign ap1_wr = sat24(MulPW'(sat24(MulPW'(sum))) + MulPW'(rd_a1 >>> 1));
  assign ap2_y  = sat24(MulPW'(rd_a2) - MulPW'(rev));
  assign ap2_wr = sat24(MulPW'(rev) + MulPW'(rd_a2 >>> 1));

  // s*(1-w)*32 + rev*w = s<<21 + (rev - s*32)*w, then truncate toward zero
  assign mix_acc = ((state == S_MXA) ? (MulPW'(sa) <<< 21) : (MulPW'(sb) <<< 21)) + mul_p;
  assign mix_rnd = mix_acc[MulPW-1] ? mix_acc + MulPW'(21'h1fffff) : mix_acc;
  assign mix_o   = sat16(mix_rnd >>> 21);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_IDLE: begin
        mul_start = in_valid;
        mul_a     = MulAW'(FB_SCALE);
        mul_b     = MulBW'(room_size);
      end
      S_CY: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(store[k]) - MulAW'(comb_rd);
        mul_b     = MulBW'(damping);
      end
      S_CM1: begin
        mul_start = mul_done;
        mul_a     = MulAW'(store_new);
        mul_b     = MulBW'(fb);
      end
      S_AP2: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(ap2_y) - (MulAW'(sa) <<< 5);
        mul_b     = wsat;
      end
      S_MXA: begin
        mul_start = mul_done && !mono_mode;
        mul_a     = MulAW'(rev) - (MulAW'(sb) <<< 5);
        mul_b     = wsat;
      end
      default: ;
    endcase
  end

  assign comb_wr = (state == S_CM2) && mul_done;
  assign we_c1 = clearing ? (int'(clr_cnt) < COMB1_LEN) : (comb_wr && k == 2'd0);
  assign we_c2 = clearing ? (int'(clr_cnt) < COMB2_LEN) : (comb_wr && k == 2'd1);
  assign we_c3 = clearing ? (int'(clr_cnt) < COMB3_LEN) : (comb_wr && k == 2'd2);
  assign we_c4 = clearing ? (int'(clr_cnt) < COMB4_LEN) : (comb_wr && k == 2'd3);
  assign we_a1 = clearing ? (int'(clr_cnt) < AP1_LEN) : (state == S_AP1);
  assign we_a2 = clearing ? (int'(clr_cnt) < AP2_LEN) : (state == S_AP2);

  cap_rvb_ram #(.WIDTH(24), .DEPTH(COMB1_LEN)) u_comb1 (
    .clk(clk), .we(we_c1), .addr(clearing ? clr_cnt[C1W-1:0] : cidx1),
    .wdata(clearing ? '0 : line_wr), .rdata(rd_c1));
  cap_rvb_ram #(.WIDTH(24), .DEPTH(COMB2_LEN)) u_comb2 (
    .clk(clk), .we(we_c2), .addr(clearing ? clr_cnt[C2W-1:0] : cidx2),
    .wdata(clearing ? '0 : line_wr), .rdata(rd_c2));
  cap_rvb_ram #(.WIDTH(24), .DEPTH(COMB3_LEN)) u_comb3 (
    .clk(clk), .we(we_c3), .addr(clearing ? clr_cnt[C3W-1:0] : cidx3),
    .wdata(clearing ? '0 : line_wr), .rdata(rd_c3));
  cap_rvb_ram #(.WIDTH(24), .DEPTH(COMB4_LEN)) u_comb4 (
    .clk(clk), .we(we_c4), .addr(clearing ? clr_cnt[C4W-1:0] : cidx4),
    .wdata(clearing ? '0 : line_wr), .rdata(rd_c4));
  cap_rvb_ram #(.WIDTH(24), .DEPTH(AP1_LEN)) u_ap1 (
    .clk(clk), .we(we_a1), .addr(clearing ? clr_cnt[A1W-1:0] : aidx1),
    .wdata(clearing ? '0 : ap1_wr), .rdata(rd_a1));
  cap_rvb_ram #(.WIDTH(24), .DEPTH(AP2_LEN)) u_ap2 (
    .clk(clk), .we(we_a2), .addr(clearing ? clr_cnt[A2W-1:0] : aidx2),
    .wdata(clearing ? '0 : ap2_wr), .rdata(rd_a2));

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      k         <= '0;
      out_valid <= 1'b0;
      cidx1 <= '0;
      cidx2 <= '0;
      cidx3 <= '0;
      cidx4 <= '0;
      aidx1 <= '0;
      aidx2 <= '0;
      for (int i = 0; i < 4; i++) begin
        store[i] <= '0;
      end
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (int'(clr_cnt) == MAXLEN - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FB;
          end
        end
        S_FB: begin
          if (mul_done) begin
            k     <= '0;
            state <= S_CY;
          end
        end
        S_CY: begin
          state <= S_CM1;
        end
        S_CM1: begin
          if (mul_done) begin
            store[k] <= store_new;
            state    <= S_CM2;
          end
        end
        S_CM2: begin
          if (mul_done) begin
            case (k)
              2'd0:    cidx1 <= (cidx1 == C1W'(COMB1_LEN - 1)) ? '0 : cidx1 + 1'b1;
              2'd1:    cidx2 <= (cidx2 == C2W'(COMB2_LEN - 1)) ? '0 : cidx2 + 1'b1;
              2'd2:    cidx3 <= (cidx3 == C3W'(COMB3_LEN - 1)) ? '0 : cidx3 + 1'b1;
              default: cidx4 <= (cidx4 == C4W'(COMB4_LEN - 1)) ? '0 : cidx4 + 1'b1;
            endcase
            k     <= k + 2'd1;
            state <= (k == 2'd3) ? S_AP1 : S_CY;
          end
        end
        S_AP1: begin
          aidx1 <= (aidx1 == A1W'(AP1_LEN - 1)) ? '0 : aidx1 + 1'b1;
          state <= S_AP2;
        end
        S_AP2: begin
          aidx2 <= (aidx2 == A2W'(AP2_LEN - 1)) ? '0 : aidx2 + 1'b1;
          state <= S_MXA;
        end
        S_MXA: begin
          if (mul_done) begin
            state <= mono_mode ? S_OUT : S_MXB;
          end
        end
        S_MXB: begin
          if (mul_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sa        <= sample_a;
        sb        <= sample_b;
        mono_mode <= (channel_count == 2'd1);
        mono      <= (channel_count == 2'd1) ? (21'(sample_a) <<< 5)
                                             : ((21'(sample_a) + 21'(sample_b)) <<< 4);
        wsat      <= (wet_mix > WET_MAX) ? WET_MAX : wet_mix;
        sum       <= '0;
      end
      S_FB: begin
        if (mul_done) begin
          fb <= mul_p[31:16] + FB_OFFSET;
        end
      end
      S_CY: begin
        y <= comb_rd;
      end
      S_CM2: begin
        if (mul_done) begin
          sum <= sum + 27'(y);
        end
      end
      S_AP1: begin
        rev <= ap1_y;
      end
      S_AP2: begin
        rev <= ap2_y;
      end
      S_MXA: begin
        if (mul_done) begin
          res_a <= mix_o;
          res_b <= '0;
        end
      end
      S_MXB: begin
        if (mul_done) begin
          res_b <= mix_o;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_a <= res_a;
          out_b <= res_b;
        end
      end
      default: ;
    endcase
  end

  a_clear_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (cidx1 == '0 && cidx2 == '0 && cidx3 == '0 && cidx4 == '0 &&
                          aidx1 == '0 && aidx2 == '0))
    else $error("delay index moved during clearing pass");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_FB || state == S_CM1 || state == S_CM2 ||
                  state == S_MXA || state == S_MXB))
    else $error("multiplier result arrived outside a waiting state");

  a_mono_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && mono_mode) |-> (res_b == '0))
    else $error("mono frame produced nonzero second channel");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result left while output register held an untaken transfer");

endmodule

@@ hw/rtl/cap_rvb_ram.sv @@
module cap_rvb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/cap_rvb_smul.sv @@
module cap_rvb_smul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cap_rvb_pkg::mul_a_t    a,
  input  cap_rvb_pkg::mul_b_t    b,
  output logic                   done,
  output cap_rvb_pkg::mul_p_t    p
);
  import cap_rvb_pkg::*;

  // shift-add, one multiplier bit per cycle, LSB first
  mul_p_t      acc;
  mul_p_t      ar;
  mul_b_t      br;
  logic [4:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(MulBW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ar  <= MulPW'(a);
      br  <= b;
    end else if (busy) begin
      if (br[0]) begin
        acc <= acc + ar;
      end
      ar <= ar <<< 1;
      br <= br >> 1;
    end
  end

  assign p = acc;
endmodule

@@ tb/sv/comb_allpass_reverb_top_tb.sv @@
module comb_allpass_reverb_top_tb;
  import cap_rvb_pkg::*;

  localparam int C1 = 1116, C2 = 1188, C3 = 1277, C4 = 1356;
  localparam int A1 = 556, A2 = 441;
  localparam int LIMIT = 1500000;
  localparam int DRAIN = 260;

  typedef struct packed {
    sample_t a;
    sample_t b;
  } frame_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  sample_t     sample_a = '0, sample_b = '0;
  logic        out_valid;
  logic        out_stall = 0;
  sample_t     out_a, out_b;

  comb_allpass_reverb_top #(
    .COMB1_LEN(C1), .COMB2_LEN(C2), .COMB3_LEN(C3), .COMB4_LEN(C4),
    .AP1_LEN(A1), .AP2_LEN(A2)
  ) i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // register shadows
  logic [1:0]  cfg_chan = 2'd2;
  logic [15:0] cfg_room = 16'd32768, cfg_damp = 16'd32768;
  logic [16:0] cfg_wet = 17'd19661;

  // reverb state
  longint comb_mem [4][C4];
  longint comb_store [4];
  int     comb_pos [4];
  int     comb_len [4] = '{C1, C2, C3, C4};
  longint ap_mem [2][A1];
  int     ap_pos [2];
  int     ap_len [2] = '{A1, A2};

  frame_t pending_frames [$];
  frame_t predicted_outs [$];
  int     errors = 0;
  int     cycles = 0;
  int     hold_cycles = 0;
  bit     calm = 0;
  bit     frame_taken = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic longint sat_q24(longint x);
    return clip(x, -8388608, 8388607);
  endfunction

  function automatic sample_t mix_channel(longint s, longint rev, longint w);
    longint acc, o;
    acc = s * (65536 - w) * 32 + rev * w;
    o = acc >= 0 ? (acc >>> 21) : -((-acc) >>> 21);
    return sample_t'(clip(o, -32768, 32767));
  endfunction

  function automatic frame_t reverb_predict(frame_t f);
    longint a, b, mono, fb, d, w, sum, rev, y, bb;
    bit     is_mono;
    frame_t r;
    a = f.a;
    b = f.b;
    is_mono = (cfg_chan == 2'd1);
    mono = is_mono ? a * 32 : (a + b) * 16;
    fb = ((longint'(cfg_room) * 58982) >>> 16) + 3277;
    d = cfg_damp;
    w = cfg_wet > 17'd65536 ? 65536 : longint'(cfg_wet);
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      y = comb_mem[k][comb_pos[k]];
      comb_store[k] = sat_q24((y * (65536 - d) + comb_store[k] * d) >>> 16);
      comb_mem[k][comb_pos[k]] = sat_q24(mono + ((comb_store[k] * fb) >>> 16));
      comb_pos[k] = (comb_pos[k] + 1) % comb_len[k];
      sum += y;
    end
    rev = sat_q24(sum);
    for (int k = 0; k < 2; k++) begin
      bb = ap_mem[k][ap_pos[k]];
      ap_mem[k][ap_pos[k]] = sat_q24(rev + (bb >>> 1));
      ap_pos[k] = (ap_pos[k] + 1) % ap_len[k];
      rev = sat_q24(bb - rev);
    end
    r.a = mix_channel(a, rev, w);
    r.b = is_mono ? sample_t'(0) : mix_channel(b, rev, w);
    return r;
  endfunction

  // input side: acceptance at the rising edge, new payload at the falling edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && in_valid && !in_stall) begin
      predicted_outs.push_back(reverb_predict(pending_frames.pop_front()));
      frame_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || frame_taken) begin
      frame_taken = 0;
      if (!rst && pending_frames.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        in_valid <= 1;
        sample_a <= pending_frames[0].a;
        sample_b <= pending_frames[0].b;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outs.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer out_a=%0d out_b=%0d", $time, out_a, out_b);
      end else begin
        want = predicted_outs.pop_front();
        if (out_a !== want.a) begin
          errors++;
          $display("%0t: out_a expected %0d actual %0d", $time, want.a, out_a);
        end
        if (out_b !== want.b) begin
          errors++;
          $display("%0t: out_b expected %0d actual %0d", $time, want.b, out_b);
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CHANNELS: cfg_chan = val[1:0];
      REG_ROOM:     cfg_room = val[15:0];
      REG_DAMPING:  cfg_damp = val[15:0];
      REG_WET:      cfg_wet  = val[16:0];
      default:      ;
    endcase
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_regs(logic [1:0] ch, logic [15:0] room, logic [15:0] damp,
                          logic [16:0] wet);
    reg_write(REG_CHANNELS, 32'(ch));
    reg_write(REG_ROOM, 32'(room));
    reg_write(REG_DAMPING, 32'(damp));
    reg_write(REG_WET, 32'(wet));
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return sample_t'($signed($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    frame_t f;
    for (int i = 0; i < n; i++) begin
      f.a = rand_sample();
      f.b = rand_sample();
      pending_frames.push_back(f);
    end
  endtask

  task automatic drain();
    wait (pending_frames.size() == 0 && predicted_outs.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    sample_t edge_vals [6] = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh4000};
    frame_t f;
    for (int k = 0; k < 4; k++) begin
      comb_store[k] = 0;
      comb_pos[k] = 0;
      for (int j = 0; j < C4; j++) comb_mem[k][j] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      ap_pos[k] = 0;
      for (int j = 0; j < A1; j++) ap_mem[k][j] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset values, directed extremes
    for (int i = 0; i < 6; i++) begin
      f.a = edge_vals[i];
      f.b = edge_vals[5 - i];
      pending_frames.push_back(f);
    end
    for (int i = 0; i < 8; i++) begin
      f.a = 16'sh7fff;
      f.b = 16'sh7fff;
      pending_frames.push_back(f);
    end
    for (int i = 0; i < 6; i++) begin
      f.a = 16'sh8000;
      f.b = 16'sh8000;
      pending_frames.push_back(f);
    end
    drain();

    // mono, full feedback, no damping, fully wet; long receiver hold-off
    set_regs(2'd1, 16'hffff, 16'h0000, 17'd65536);
    queue_random(120);
    hold_cycles = 3000;
    drain();

    // channel code 0 is stereo; fully dry, full damping
    set_regs(2'd0, 16'h0000, 16'hffff, 17'd0);
    queue_random(100);
    drain();

    // code 3 is stereo; wet above one saturates
    set_regs(2'd3, 16'($urandom), 16'($urandom), 17'h1ffff);
    queue_random(100);
    drain();

    // no idling on either side
    calm = 1;
    set_regs(2'd2, 16'd32768, 16'd16384, 17'd40000);
    queue_random(120);
    drain();
    calm = 0;

    for (int p = 0; p < 3; p++) begin
      set_regs(2'($urandom_range(1, 2)), 16'($urandom), 16'($urandom),
               17'($urandom_range(0, 70000)));
      queue_random(90);
      drain();
    end

    if (errors == 0 && predicted_outs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ comb_allpass_reverb_top.f @@
hw/rtl/cap_rvb_pkg.sv
hw/rtl/cap_rvb_ram.sv
hw/rtl/cap_rvb_smul.sv
hw/rtl/comb_allpass_reverb_top.sv
tb/sv/comb_allpass_reverb_top_tb.sv
